// File: hdl/md5_short_message_nibble_match_defines.svh
// assertion macros for the md5 short message nibble matcher
// no dependencies; included by the modules that carry assertions
`ifndef MD5_SHORT_MESSAGE_NIBBLE_MATCH_DEFINES_SVH
`define MD5_SHORT_MESSAGE_NIBBLE_MATCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MD5SNM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("md5snm assertion failed");

// next-cycle implication, checked outside reset
`define MD5SNM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("md5snm assertion failed");

`endif

// File: hdl/md5snm_pkg.sv
// shared types, constants and helper functions for the md5 nibble matcher
// no dependencies
package md5snm_pkg;

    localparam int MSG_W             = 56;
    localparam int MSG_BYTES_DEFAULT = 7;
    localparam int ROUNDS            = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HIGH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LOW     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_NIBBLES = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NIBBLE_OFFSET  = 3'd3;

    // initial chaining values
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_TABLE [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // one word moving down the round chain
    typedef struct packed {
        logic             valid;
        logic [MSG_W-1:0] message;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      c;
        logic [31:0]      d;
    } t_stage;

    // match settings seen by the final stage
    typedef struct packed {
        logic [127:0] target;
        logic [5:0]   nibbles;
        logic [4:0]   offset;
    } t_cfg;

    // message word schedule index of a round
    function automatic logic [3:0] msg_index(input int round);
        int g;
        if (round < 16)      g = round;
        else if (round < 32) g = 5 * round + 1;
        else if (round < 48) g = 3 * round + 5;
        else                 g = 7 * round;
        return 4'(g % 16);
    endfunction

    // rotate amount of a round
    function automatic int rot_amount(input int round);
        return ROT_TABLE[((round / 16) * 4) + (round % 4)];
    endfunction

    // word of the single padded block: message bytes, 0x80, zeros, bit length
    function automatic logic [31:0] block_word(input logic [MSG_W-1:0] msg,
                                               input logic [3:0] idx,
                                               input int nbytes);
        logic [63:0] m;
        logic [63:0] lo;
        logic [31:0] w;
        m  = {8'h00, msg};
        lo = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes) lo[8*i +: 8] = m[8*i +: 8];
            else if (i == nbytes) lo[8*i +: 8] = 8'h80;
        end
        case (idx)
            4'd0:    w = lo[31:0];
            4'd1:    w = lo[63:32];
            4'd14:   w = 32'(nbytes * 8);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// File: hdl/md5snm_round_cell.sv
// one md5 round as a registered cell of the round chain
// depends on md5snm_pkg
module md5snm_round_cell #(
    parameter int ROUND     = 0,
    parameter int MSG_BYTES = md5snm_pkg::MSG_BYTES_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  md5snm_pkg::t_stage i_stage,
    output md5snm_pkg::t_stage o_stage
);

    localparam int          S = md5snm_pkg::rot_amount(ROUND);
    localparam logic [3:0]  G = md5snm_pkg::msg_index(ROUND);
    localparam logic [31:0] K = md5snm_pkg::K_TABLE[ROUND];

    logic [31:0] f;
    logic [31:0] w;
    logic [31:0] t;
    logic [31:0] rot;
    md5snm_pkg::t_stage r_stage;
    md5snm_pkg::t_stage n_stage;

    // round function of this quarter
    always_comb begin
        if (ROUND < 16)      f = i_stage.d ^ (i_stage.b & (i_stage.c ^ i_stage.d));
        else if (ROUND < 32) f = i_stage.c ^ (i_stage.d & (i_stage.b ^ i_stage.c));
        else if (ROUND < 48) f = i_stage.b ^ i_stage.c ^ i_stage.d;
        else                 f = i_stage.c ^ (i_stage.b | ~i_stage.d);
    end

    // message word, sum, rotate and state shuffle
    always_comb begin
        w   = md5snm_pkg::block_word(i_stage.message, G, MSG_BYTES);
        t   = i_stage.a + f + K + w;
        rot = (t << S) | (t >> (32 - S));
        n_stage.valid   = i_stage.valid;
        n_stage.message = i_stage.message;
        n_stage.a       = i_stage.d;
        n_stage.d       = i_stage.c;
        n_stage.c       = i_stage.b;
        n_stage.b       = i_stage.b + rot;
    end

    // valid bit and working state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.message <= n_stage.message;
            r_stage.a       <= n_stage.a;
            r_stage.b       <= n_stage.b;
            r_stage.c       <= n_stage.c;
            r_stage.d       <= n_stage.d;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/md5snm_finish.sv
// final digest add, nibble window compare and output register
// depends on md5snm_pkg and md5_short_message_nibble_match_defines.svh
`include "md5_short_message_nibble_match_defines.svh"

module md5snm_finish (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  md5snm_pkg::t_stage i_stage,
    input  md5snm_pkg::t_cfg   i_cfg,
    output logic               o_valid,
    output logic [63:0]        o_digest_low,
    output logic [63:0]        o_digest_high,
    output logic               o_match
);

    logic         r_dig_valid;
    logic [127:0] r_dig;
    logic [127:0] n_dig;
    logic [127:0] hex;
    logic [127:0] window;
    logic [127:0] mask;
    logic [6:0]   span;
    logic         n_match;
    logic         r_valid;
    logic [127:0] r_out_dig;
    logic         r_match;

    // add chaining values, word a in the low bits
    assign n_dig = {i_stage.d + md5snm_pkg::IV_D, i_stage.c + md5snm_pkg::IV_C,
                    i_stage.b + md5snm_pkg::IV_B, i_stage.a + md5snm_pkg::IV_A};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig_valid <= 1'b0;
        end else if (i_en) begin
            r_dig_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dig <= n_dig;
        end
    end

    // hex string order: digest byte 0 in the top bits, high nibble first
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            hex[127 - 8*j -: 8] = r_dig[8*j +: 8];
        end
    end

    // align the window to the target and mask the compared nibbles
    always_comb begin
        window  = hex << {i_cfg.offset, 2'b00};
        mask    = ~({128{1'b1}} >> {i_cfg.nibbles, 2'b00});
        span    = {2'b00, i_cfg.offset} + {1'b0, i_cfg.nibbles};
        n_match = (span <= 7'd32) && (((window ^ i_cfg.target) & mask) == '0);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_dig_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_dig <= r_dig;
            r_match   <= n_match;
        end
    end

    assign o_valid       = r_valid;
    assign o_digest_low  = r_out_dig[63:0];
    assign o_digest_high = r_out_dig[127:64];
    assign o_match       = r_match;

    `MD5SNM_ASSERT_NEXT(a_dig_reaches_out, r_dig_valid && i_en, r_valid)
    `MD5SNM_ASSERT_NEXT(a_dig_holds, r_dig_valid && !i_en, r_dig_valid && $stable(r_dig))
    `MD5SNM_ASSERT_NOW(a_match_in_window, r_valid && r_match,
        ({2'b00, i_cfg.offset} + {1'b0, i_cfg.nibbles}) <= 7'd32)

endmodule

// File: hdl/md5_short_message_nibble_match.sv
// each accepted word passes through 64 round cells, the digest add stage and the compare
// and output register; throughput one word per cycle while i_stall does not hold the chain
// the whole chain moves as one: a stalled result in the output register holds
// every cell, so input stall follows output stall in the same cycle
// reset clears all valid bits and loads the target registers with zero,
// the nibble count with 32 and the offset with 0
module md5_short_message_nibble_match #(
    parameter int MESSAGE_BYTES = md5snm_pkg::MSG_BYTES_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [md5snm_pkg::MSG_W-1:0]       i_message,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [63:0]                        o_digest_low,
    output logic [63:0]                        o_digest_high,
    output logic                               o_match,
    input  logic                               i_cfg_we,
    input  logic [md5snm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [md5snm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic               en;
    logic [63:0]        r_target_high;
    logic [63:0]        r_target_low;
    logic [5:0]         r_target_nibbles;
    logic [4:0]         r_nibble_offset;
    md5snm_pkg::t_cfg   cfg;
    md5snm_pkg::t_stage chain [md5snm_pkg::ROUNDS + 1];

    // chain advances unless a finished word is waiting
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_high    <= '0;
            r_target_low     <= '0;
            r_target_nibbles <= 6'd32;
            r_nibble_offset  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                md5snm_pkg::CFG_TARGET_HIGH:    r_target_high    <= i_cfg_data;
                md5snm_pkg::CFG_TARGET_LOW:     r_target_low     <= i_cfg_data;
                md5snm_pkg::CFG_TARGET_NIBBLES: r_target_nibbles <= i_cfg_data[5:0];
                md5snm_pkg::CFG_NIBBLE_OFFSET:  r_nibble_offset  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign cfg.target  = {r_target_high, r_target_low};
    assign cfg.nibbles = r_target_nibbles;
    assign cfg.offset  = r_nibble_offset;

    // head of the chain: new word with the initial chaining values
    assign chain[0].valid   = i_valid;
    assign chain[0].message = i_message;
    assign chain[0].a       = md5snm_pkg::IV_A;
    assign chain[0].b       = md5snm_pkg::IV_B;
    assign chain[0].c       = md5snm_pkg::IV_C;
    assign chain[0].d       = md5snm_pkg::IV_D;

    // row of round cells
    for (genvar r = 0; r < md5snm_pkg::ROUNDS; r++) begin : g_round
        md5snm_round_cell #(
            .ROUND     (r),
            .MSG_BYTES (MESSAGE_BYTES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (chain[r]),
            .o_stage (chain[r+1])
        );
    end

    // digest add, compare and output
    md5snm_finish u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_stage       (chain[md5snm_pkg::ROUNDS]),
        .i_cfg         (cfg),
        .o_valid       (o_valid),
        .o_digest_low  (o_digest_low),
        .o_digest_high (o_digest_high),
        .o_match       (o_match)
    );

endmodule
